/* hw/rtl/pasrb_pkg.sv */
// ----------------------------------------------------------------------------
// pasrb_pkg
// Shared types, codes and defaults for the paired ADC scan ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pasrb_pkg;

    // Default sizes of the block
    localparam int CHANNELS_DEFAULT   = 8;
    localparam int RING_DEPTH_DEFAULT = 1024;
    localparam int BLOCK_DEFAULT      = 128;

    // Field widths
    localparam int COMMAND_W  = 2;
    localparam int RAW_W      = 12;
    localparam int KIND_W     = 2;
    localparam int CHANNEL_W  = 3;
    localparam int VALUE_W    = 16;
    localparam int PIN_W      = 8;
    localparam int LOST_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 4;

    // Command codes
    localparam logic [COMMAND_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_DRAIN  = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP       = 1'd1;

    // Register reset values
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE_FIRST,
        ST_WRITE_SECOND,
        ST_UPDATE,
        ST_EMIT,
        ST_CHECK,
        ST_READ,
        ST_READ_WAIT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/pasrb_if.sv */
// ----------------------------------------------------------------------------
// pasrb_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pasrb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [pasrb_pkg::COMMAND_W-1:0]     command;
    logic [pasrb_pkg::RAW_W-1:0]         first_sample;
    logic [pasrb_pkg::RAW_W-1:0]         second_sample;

    modport source (output valid, command, first_sample, second_sample, input ready);
    modport sink   (input valid, command, first_sample, second_sample, output ready);
endinterface

interface pasrb_result_if;
    logic                                valid;
    logic                                ready;
    logic [pasrb_pkg::KIND_W-1:0]        kind;
    logic [pasrb_pkg::CHANNEL_W-1:0]     channel;
    logic signed [pasrb_pkg::VALUE_W-1:0] sample_value;
    logic                                block_end;
    logic                                last;
    logic                                start_read;
    logic [pasrb_pkg::PIN_W-1:0]         first_pin;
    logic [pasrb_pkg::PIN_W-1:0]         second_pin;
    logic                                halted;
    logic [pasrb_pkg::LOST_W-1:0]        lost_count;

    modport source (output valid, kind, channel, sample_value, block_end, last, start_read,
                    first_pin, second_pin, halted, lost_count, input ready);
    modport sink   (input valid, kind, channel, sample_value, block_end, last, start_read,
                    first_pin, second_pin, halted, lost_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/paired_adc_scan_ring_buffer.sv */
// ----------------------------------------------------------------------------
// paired_adc_scan_ring_buffer
// Two-converter scan sequencer writing a per-channel ring buffer, with
// block-wise drain of scaled frames and a saturating lost-sample count.
// ----------------------------------------------------------------------------
//  channel   role    handshake        payload
//  cmd       sink    valid/ready      command, first_sample, second_sample
//  result    source  valid/ready      kind .. lost_count, one or more per item
//  cfg_*     write   cfg_write_en     cfg_index selects register, cfg_data
//
//  A conversion item while scanning runs two writes through the single store
//  write port, an update and an emit; a conversion item while halted, clear,
//  unused commands take the update and emit, a refused drain the check and emit.
//  A drain checks, then reads each active channel in turn: the store has one
//  registered read port, so each channel costs an address and a data state.
//  Reset clears all control state at once; the store needs no clearing.
//  A stalled result holds the sequencer in place until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module paired_adc_scan_ring_buffer #(
    parameter int CHANNELS   = pasrb_pkg::CHANNELS_DEFAULT,
    parameter int RING_DEPTH = pasrb_pkg::RING_DEPTH_DEFAULT,
    parameter int BLOCK      = pasrb_pkg::BLOCK_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pasrb_cmd_if.sink                               cmd,
    pasrb_result_if.source                          result,
    input  wire logic                               cfg_write_en,
    input  wire logic [pasrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pasrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW        = $clog2(RING_DEPTH);
    localparam int FW        = $clog2(BLOCK + 1);
    localparam int SW        = (PW + 1 > FW) ? PW + 1 : FW;
    localparam int CW        = pasrb_pkg::CHANNEL_W;
    localparam int MEM_DEPTH = (1 << CW) * (1 << PW);
    localparam int CAP_EVEN  = CHANNELS - (CHANNELS % 2);
    localparam int CAP_INT   = (CAP_EVEN > 8) ? 8 : CAP_EVEN;

    localparam logic [pasrb_pkg::COUNT_W-1:0] CAP        = pasrb_pkg::COUNT_W'(CAP_INT);
    localparam logic [pasrb_pkg::COUNT_W-1:0] MIN_COUNT  = pasrb_pkg::COUNT_W'(2);
    localparam logic [PW-1:0]                 POS_LAST   = PW'(RING_DEPTH - 1);
    localparam logic [SW-1:0]                 DEPTH_S    = SW'(RING_DEPTH);
    localparam logic [SW-1:0]                 BLOCK_S    = SW'(BLOCK);
    localparam logic [FW-1:0]                 BLOCK_F    = FW'(BLOCK);
    localparam logic [CW:0]                   CHANNELS_C = (CW + 1)'(CHANNELS > 8 ? 8 : CHANNELS);

    // Sample store, one row of RING_DEPTH entries per channel
    logic [pasrb_pkg::RAW_W-1:0] store_mem [MEM_DEPTH];

    pasrb_pkg::state_t state_reg, state_next;

    logic [pasrb_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [pasrb_pkg::CFG_DATA_W-1:0] pin_map_reg, pin_map_next;

    logic [pasrb_pkg::COMMAND_W-1:0] command_reg, command_next;
    logic [pasrb_pkg::RAW_W-1:0]     first_reg, first_next;
    logic [pasrb_pkg::RAW_W-1:0]     second_reg, second_next;

    logic [1:0]                   pair_reg, pair_next;
    logic                         halted_reg, halted_next;
    logic [PW-1:0]                wpos_reg, wpos_next;
    logic [PW-1:0]                rpos_reg, rpos_next;
    logic [pasrb_pkg::LOST_W-1:0] lost_reg, lost_next;
    logic [FW-1:0]                frames_reg, frames_next;
    logic [CW-1:0]                index_reg, index_next;
    logic                         bend_reg, bend_next;
    logic                         start_reg, start_next;
    logic                         refuse_reg, refuse_next;

    logic [pasrb_pkg::RAW_W-1:0]  rdata_reg;

    // Result register
    logic                                 out_valid_reg, out_valid_next;
    logic [pasrb_pkg::KIND_W-1:0]         out_kind_reg, out_kind_next;
    logic [CW-1:0]                        out_channel_reg, out_channel_next;
    logic [pasrb_pkg::VALUE_W-1:0]        out_value_reg, out_value_next;
    logic                                 out_bend_reg, out_bend_next;
    logic                                 out_last_reg, out_last_next;
    logic                                 out_start_reg, out_start_next;
    logic [pasrb_pkg::PIN_W-1:0]          out_pin0_reg, out_pin0_next;
    logic [pasrb_pkg::PIN_W-1:0]          out_pin1_reg, out_pin1_next;
    logic                                 out_halted_reg, out_halted_next;
    logic [pasrb_pkg::LOST_W-1:0]         out_lost_reg, out_lost_next;

    // Store port controls
    logic                        mem_we;
    logic [CW+PW-1:0]            mem_waddr;
    logic [pasrb_pkg::RAW_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [CW+PW-1:0]            mem_raddr;

    // Derived values
    logic [pasrb_pkg::COUNT_W-1:0] active;
    logic [2:0]                    pairs;
    logic [CW-1:0]                 write_ch;
    logic [CW-1:0]                 pin_ch0;
    logic [CW-1:0]                 pin_ch1;
    logic [SW-1:0]                 stored;
    logic [PW-1:0]                 wpos_inc;
    logic [PW-1:0]                 rpos_inc;
    logic                          out_free;
    logic                          in_take;
    logic [FW-1:0]                 frames_dec;

    // Effective channel count: even, clamped to 2..CAP
    always_comb
    begin
        active = {count_reg[pasrb_pkg::COUNT_W-1:1], 1'b0};
        if (active > CAP)
        begin
            active = CAP;
        end
        if (active < MIN_COUNT)
        begin
            active = MIN_COUNT;
        end
    end

    assign pairs    = active[3:1];
    assign write_ch = {pair_reg, (state_reg == pasrb_pkg::ST_WRITE_SECOND)};
    assign pin_ch0  = {pair_reg, 1'b0};
    assign pin_ch1  = {pair_reg, 1'b1};
    assign wpos_inc = (wpos_reg == POS_LAST) ? '0 : wpos_reg + PW'(1);
    assign rpos_inc = (rpos_reg == POS_LAST) ? '0 : rpos_reg + PW'(1);

    // Frames held in the ring; equal positions while scanning count as empty
    always_comb
    begin
        if (halted_reg)
        begin
            stored = DEPTH_S;
        end
        else if (wpos_reg >= rpos_reg)
        begin
            stored = SW'(wpos_reg) - SW'(rpos_reg);
        end
        else
        begin
            stored = SW'(wpos_reg) + DEPTH_S - SW'(rpos_reg);
        end
    end

    assign frames_dec = ((frames_reg == '0) ? BLOCK_F : frames_reg) - FW'(1);
    assign out_free   = !out_valid_reg || result.ready;
    assign in_take    = cmd.valid && (state_reg == pasrb_pkg::ST_IDLE);
    assign cmd.ready  = (state_reg == pasrb_pkg::ST_IDLE);

    // Store write and read addressing
    assign mem_we    = ((state_reg == pasrb_pkg::ST_WRITE_FIRST)
                        || (state_reg == pasrb_pkg::ST_WRITE_SECOND))
                       && ({1'b0, write_ch} < CHANNELS_C);
    assign mem_waddr = {write_ch, wpos_reg};
    assign mem_wdata = (state_reg == pasrb_pkg::ST_WRITE_SECOND) ? second_reg : first_reg;
    assign mem_re    = (state_reg == pasrb_pkg::ST_READ);
    assign mem_raddr = {index_reg, rpos_reg};

    // Store access
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    // Sequencer: next state, state updates and result loading
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pin_map_next     = pin_map_reg;
        command_next     = command_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        pair_next        = pair_reg;
        halted_next      = halted_reg;
        wpos_next        = wpos_reg;
        rpos_next        = rpos_reg;
        lost_next        = lost_reg;
        frames_next      = frames_reg;
        index_next       = index_reg;
        bend_next        = bend_reg;
        start_next       = start_reg;
        refuse_next      = refuse_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_kind_next    = out_kind_reg;
        out_channel_next = out_channel_reg;
        out_value_next   = out_value_reg;
        out_bend_next    = out_bend_reg;
        out_last_next    = out_last_reg;
        out_start_next   = out_start_reg;
        out_pin0_next    = out_pin0_reg;
        out_pin1_next    = out_pin1_reg;
        out_halted_next  = out_halted_reg;
        out_lost_next    = out_lost_reg;

        // Configuration writes
        if (cfg_write_en)
        begin
            if (cfg_index == pasrb_pkg::REG_CHANNEL_COUNT)
            begin
                count_next = cfg_data[pasrb_pkg::COUNT_W-1:0];
            end
            else if (cfg_index == pasrb_pkg::REG_PIN_MAP)
            begin
                pin_map_next = cfg_data;
            end
        end

        case (state_reg)
            pasrb_pkg::ST_IDLE:
            begin
                // Latch the item and pick its path
                if (in_take)
                begin
                    command_next = cmd.command;
                    first_next   = cmd.first_sample;
                    second_next  = cmd.second_sample;
                    if (cmd.command == pasrb_pkg::CMD_DRAIN)
                    begin
                        state_next = pasrb_pkg::ST_CHECK;
                    end
                    else if ((cmd.command == pasrb_pkg::CMD_SAMPLE) && !halted_reg)
                    begin
                        state_next = pasrb_pkg::ST_WRITE_FIRST;
                    end
                    else
                    begin
                        state_next = pasrb_pkg::ST_UPDATE;
                    end
                end
            end

            pasrb_pkg::ST_WRITE_FIRST:
            begin
                state_next = pasrb_pkg::ST_WRITE_SECOND;
            end

            pasrb_pkg::ST_WRITE_SECOND:
            begin
                state_next = pasrb_pkg::ST_UPDATE;
            end

            pasrb_pkg::ST_UPDATE:
            begin
                // Advance scan position, halt or resume, count or clear lost samples
                start_next  = 1'b0;
                refuse_next = 1'b0;
                state_next  = pasrb_pkg::ST_EMIT;
                case (command_reg)
                    pasrb_pkg::CMD_SAMPLE:
                    begin
                        if (!halted_reg)
                        begin
                            if ({1'b0, pair_reg} + 3'd1 < pairs)
                            begin
                                pair_next  = pair_reg + 2'd1;
                                start_next = 1'b1;
                            end
                            else
                            begin
                                wpos_next = wpos_inc;
                                pair_next = 2'd0;
                                if (wpos_inc != rpos_reg)
                                begin
                                    start_next = 1'b1;
                                end
                                else
                                begin
                                    halted_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (&lost_reg[pasrb_pkg::LOST_W-1:1])
                            begin
                                lost_next = '1;
                            end
                            else
                            begin
                                lost_next = lost_reg + pasrb_pkg::LOST_W'(2);
                            end
                            pair_next = 2'd0;
                            if (wpos_reg != rpos_reg)
                            begin
                                halted_next = 1'b0;
                                start_next  = 1'b1;
                            end
                        end
                    end
                    pasrb_pkg::CMD_CLEAR:
                    begin
                        lost_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            pasrb_pkg::ST_CHECK:
            begin
                // Refuse a new block unless a whole block is stored
                if ((frames_reg == '0) && (stored < BLOCK_S))
                begin
                    refuse_next = 1'b1;
                    state_next  = pasrb_pkg::ST_EMIT;
                end
                else
                begin
                    frames_next = frames_dec;
                    bend_next   = (frames_dec == '0);
                    index_next  = '0;
                    state_next  = pasrb_pkg::ST_READ;
                end
            end

            pasrb_pkg::ST_READ:
            begin
                state_next = pasrb_pkg::ST_READ_WAIT;
            end

            pasrb_pkg::ST_READ_WAIT:
            begin
                // Emit one scaled sample, then move to the next channel or end the frame
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = pasrb_pkg::KIND_SAMPLE;
                    out_channel_next = index_reg;
                    out_value_next   = {~rdata_reg[pasrb_pkg::RAW_W-1],
                                        rdata_reg[pasrb_pkg::RAW_W-2:0], 4'b0000};
                    out_bend_next    = bend_reg;
                    out_last_next    = ({1'b0, index_reg} + 4'd1 == active);
                    out_start_next   = 1'b0;
                    out_pin0_next    = '0;
                    out_pin1_next    = '0;
                    out_halted_next  = halted_reg;
                    out_lost_next    = lost_reg;
                    if ({1'b0, index_reg} + 4'd1 == active)
                    begin
                        rpos_next  = rpos_inc;
                        state_next = pasrb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        index_next = index_reg + CW'(1);
                        state_next = pasrb_pkg::ST_READ;
                    end
                end
            end

            pasrb_pkg::ST_EMIT:
            begin
                // Emit the single status or refusal item
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = '0;
                    out_value_next   = '0;
                    out_bend_next    = 1'b0;
                    out_last_next    = 1'b1;
                    out_halted_next  = halted_reg;
                    out_lost_next    = lost_reg;
                    if (refuse_reg)
                    begin
                        out_kind_next  = pasrb_pkg::KIND_REFUSED;
                        out_start_next = 1'b0;
                        out_pin0_next  = '0;
                        out_pin1_next  = '0;
                    end
                    else
                    begin
                        out_kind_next  = pasrb_pkg::KIND_STATUS;
                        out_start_next = start_reg;
                        out_pin0_next  = pin_map_reg[pin_ch0*pasrb_pkg::PIN_W +: pasrb_pkg::PIN_W];
                        out_pin1_next  = pin_map_reg[pin_ch1*pasrb_pkg::PIN_W +: pasrb_pkg::PIN_W];
                    end
                    state_next = pasrb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pasrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pasrb_pkg::ST_IDLE;
            count_reg     <= pasrb_pkg::CHANNEL_COUNT_RESET;
            pin_map_reg   <= '0;
            pair_reg      <= '0;
            halted_reg    <= 1'b0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            lost_reg      <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pin_map_reg   <= pin_map_next;
            pair_reg      <= pair_next;
            halted_reg    <= halted_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            lost_reg      <= lost_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        command_reg     <= command_next;
        first_reg       <= first_next;
        second_reg      <= second_next;
        index_reg       <= index_next;
        bend_reg        <= bend_next;
        start_reg       <= start_next;
        refuse_reg      <= refuse_next;
        out_kind_reg    <= out_kind_next;
        out_channel_reg <= out_channel_next;
        out_value_reg   <= out_value_next;
        out_bend_reg    <= out_bend_next;
        out_last_reg    <= out_last_next;
        out_start_reg   <= out_start_next;
        out_pin0_reg    <= out_pin0_next;
        out_pin1_reg    <= out_pin1_next;
        out_halted_reg  <= out_halted_next;
        out_lost_reg    <= out_lost_next;
    end

    // Drive the result channel
    assign result.valid        = out_valid_reg;
    assign result.kind         = out_kind_reg;
    assign result.channel      = out_channel_reg;
    assign result.sample_value = out_value_reg;
    assign result.block_end    = out_bend_reg;
    assign result.last         = out_last_reg;
    assign result.start_read   = out_start_reg;
    assign result.first_pin    = out_pin0_reg;
    assign result.second_pin   = out_pin1_reg;
    assign result.halted       = out_halted_reg;
    assign result.lost_count   = out_lost_reg;

endmodule

`default_nettype wire

/* bench/paired_adc_scan_ring_buffer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_adc_scan_ring_buffer_test
// Self-checking bench for the paired ADC scan ring buffer. A behavioral copy
// of the sequencer predicts every result item from the accepted command
// items. The bench fills the ring until scanning halts, counts lost samples,
// drains whole blocks, sweeps the channel count and pin map, and runs random
// scan and drain traffic with gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module paired_adc_scan_ring_buffer_test;

    localparam int CHANNELS    = pasrb_pkg::CHANNELS_DEFAULT;
    localparam int RING_DEPTH  = pasrb_pkg::RING_DEPTH_DEFAULT;
    localparam int BLOCK       = pasrb_pkg::BLOCK_DEFAULT;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 1500000;

    // Command code with no function in the block
    localparam logic [pasrb_pkg::COMMAND_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [pasrb_pkg::KIND_W-1:0]    kind;
        logic [pasrb_pkg::CHANNEL_W-1:0] channel;
        logic [pasrb_pkg::VALUE_W-1:0]   sample_value;
        logic                            block_end;
        logic                            last;
        logic                            start_read;
        logic [pasrb_pkg::PIN_W-1:0]     first_pin;
        logic [pasrb_pkg::PIN_W-1:0]     second_pin;
        logic                            halted;
        logic [pasrb_pkg::LOST_W-1:0]    lost_count;
    } scan_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write_en = 1'b0;
    logic [pasrb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pasrb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pasrb_cmd_if    cmd_ch ();
    pasrb_result_if result_ch ();

    paired_adc_scan_ring_buffer #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH),
        .BLOCK      (BLOCK)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Sequencer copy: configuration
    logic [pasrb_pkg::COUNT_W-1:0]    count_reg = pasrb_pkg::CHANNEL_COUNT_RESET;
    logic [pasrb_pkg::CFG_DATA_W-1:0] pin_map_reg = '0;

    // Sequencer copy: state
    int                            cur_pair = 0;
    logic                          halt_flag = 1'b0;
    logic [9:0]                    wr_frame = '0;
    logic [9:0]                    rd_frame = '0;
    logic [pasrb_pkg::LOST_W-1:0]  lost_tally = '0;
    int                            block_frames_left = 0;
    logic [pasrb_pkg::RAW_W-1:0]   raw_store [0:CHANNELS-1][0:RING_DEPTH-1];

    scan_result_t          results_due [$];

    int                    failures = 0;
    int                    cycle_count = 0;
    int                    sender_idle_pct = 14;
    int                    receiver_idle_pct = 49;
    logic                  hold_request = 1'b0;
    int                    hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer copy
    // ------------------------------------------------------------------

    function automatic int active_channels();
        int n;
        n = int'(count_reg & 4'hE);
        if (n > 8)
            n = 8;
        if (n < 2)
            n = 2;
        return n;
    endfunction

    function automatic logic [pasrb_pkg::PIN_W-1:0] pin_of(int ch);
        return pin_map_reg[(ch % 8) * 8 +: 8];
    endfunction

    function automatic int frames_in_ring();
        logic [9:0] span;
        span = wr_frame - rd_frame;
        if (halt_flag)
            return RING_DEPTH;
        return int'(span);
    endfunction

    function automatic scan_result_t blank_result(logic [pasrb_pkg::KIND_W-1:0] kind);
        scan_result_t r;
        r = '0;
        r.kind = kind;
        r.halted = halt_flag;
        r.lost_count = lost_tally;
        return r;
    endfunction

    // Work out the result items of one accepted command item
    function automatic void sequencer_step(logic [pasrb_pkg::COMMAND_W-1:0] command,
                                           logic [pasrb_pkg::RAW_W-1:0] first_raw,
                                           logic [pasrb_pkg::RAW_W-1:0] second_raw);
        int           nch;
        logic         start;
        logic         bend;
        scan_result_t r;
        nch = active_channels();
        start = 1'b0;

        if (command == pasrb_pkg::CMD_DRAIN)
        begin
            // Refuse a new block while too few frames are stored
            if (block_frames_left == 0)
            begin
                if (frames_in_ring() < BLOCK)
                begin
                    r = blank_result(pasrb_pkg::KIND_REFUSED);
                    r.last = 1'b1;
                    results_due.push_back(r);
                    return;
                end
                block_frames_left = BLOCK;
            end
            block_frames_left--;
            bend = (block_frames_left == 0);
            for (int i = 0; i < nch; i++)
            begin
                r = blank_result(pasrb_pkg::KIND_SAMPLE);
                r.channel = i[pasrb_pkg::CHANNEL_W-1:0];
                r.sample_value = {raw_store[i][rd_frame], 4'h0} + 16'h8000;
                r.block_end = bend;
                r.last = (i == nch - 1);
                results_due.push_back(r);
            end
            rd_frame = rd_frame + 1'b1;
            return;
        end

        if (command == pasrb_pkg::CMD_SAMPLE)
        begin
            if (!halt_flag)
            begin
                raw_store[2 * cur_pair][wr_frame] = first_raw;
                raw_store[2 * cur_pair + 1][wr_frame] = second_raw;
                // A pair beyond a shrunk channel count acts as the last pair
                if (cur_pair + 1 < nch / 2)
                begin
                    cur_pair++;
                    start = 1'b1;
                end
                else
                begin
                    wr_frame = wr_frame + 1'b1;
                    cur_pair = 0;
                    if (wr_frame != rd_frame)
                        start = 1'b1;
                    else
                        halt_flag = 1'b1;
                end
            end
            else
            begin
                // Count the lost pair and resume once the reader made room
                if (lost_tally > 32'hFFFF_FFFD)
                    lost_tally = 32'hFFFF_FFFF;
                else
                    lost_tally = lost_tally + 2;
                cur_pair = 0;
                if (wr_frame != rd_frame)
                begin
                    halt_flag = 1'b0;
                    start = 1'b1;
                end
            end
        end
        else if (command == pasrb_pkg::CMD_CLEAR)
        begin
            lost_tally = '0;
        end

        r = blank_result(pasrb_pkg::KIND_STATUS);
        r.start_read = start;
        r.first_pin = pin_of(2 * cur_pair);
        r.second_pin = pin_of(2 * cur_pair + 1);
        r.last = 1'b1;
        results_due.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic logic [pasrb_pkg::RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom_range(4095);
        endcase
    endfunction

    // Offer one command item and predict its results once accepted
    task automatic send_item(logic [pasrb_pkg::COMMAND_W-1:0] command,
                             logic [pasrb_pkg::RAW_W-1:0] first_raw,
                             logic [pasrb_pkg::RAW_W-1:0] second_raw);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= command;
        cmd_ch.first_sample <= first_raw;
        cmd_ch.second_sample <= second_raw;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sequencer_step(command, first_raw, second_raw);
    endtask

    // Hold the command channel until every due result has arrived
    task automatic settle_block();
        cmd_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [pasrb_pkg::CFG_IDX_W-1:0] index,
                                  logic [pasrb_pkg::CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        if (index == pasrb_pkg::REG_CHANNEL_COUNT)
            count_reg = value[pasrb_pkg::COUNT_W-1:0];
        else
            pin_map_reg = value;
    endtask

    // Result receiver: random stalls, plus a long hold on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result item with nothing due: kind %0d channel %0d",
                       result_ch.kind, result_ch.channel);
                failures++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", want.kind, result_ch.kind);
                check_field("channel", want.channel, result_ch.channel);
                check_field("sample_value", $signed(want.sample_value),
                            $signed(result_ch.sample_value));
                check_field("block_end", want.block_end, result_ch.block_end);
                check_field("last", want.last, result_ch.last);
                check_field("start_read", want.start_read, result_ch.start_read);
                check_field("first_pin", want.first_pin, result_ch.first_pin);
                check_field("second_pin", want.second_pin, result_ch.second_pin);
                check_field("halted", want.halted, result_ch.halted);
                check_field("lost_count", want.lost_count, result_ch.lost_count);
            end
        end
    end

    // Abort a run that exceeds the cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Refused drains, clear, unused code and extreme samples out of reset
    task automatic test_status_and_refusal();
        send_item(pasrb_pkg::CMD_DRAIN, 12'hFFF, 12'hFFF);
        send_item(pasrb_pkg::CMD_CLEAR, 12'h000, 12'hFFF);
        send_item(CMD_UNUSED, 12'hFFF, 12'h000);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'h000, 12'hFFF);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'hFFF, 12'h000);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'h800, 12'h7FF);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'hAAA, 12'h555);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'h555, 12'hAAA);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'h001, 12'hFFE);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'h7FF, 12'h800);
        send_item(pasrb_pkg::CMD_SAMPLE, 12'hFFF, 12'hFFF);
        send_item(pasrb_pkg::CMD_DRAIN, 12'h000, 12'h000);
        settle_block();
    endtask

    // Fill the whole ring, count lost pairs while halted, drain to resume
    task automatic test_fill_until_halt();
        write_register(pasrb_pkg::REG_PIN_MAP, {$urandom, $urandom});
        while (!halt_flag)
            send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        repeat (3) send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        send_item(pasrb_pkg::CMD_CLEAR, pick_raw(), pick_raw());
        send_item(CMD_UNUSED, pick_raw(), pick_raw());
        repeat (2) send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        repeat (BLOCK + 1) send_item(pasrb_pkg::CMD_DRAIN, pick_raw(), pick_raw());
        send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        settle_block();
    endtask

    // Write a channel count and run one frame plus one pair and a drain under it
    task automatic apply_channel_count(logic [pasrb_pkg::COUNT_W-1:0] count);
        write_register(pasrb_pkg::REG_CHANNEL_COUNT, pasrb_pkg::CFG_DATA_W'(count));
        repeat (active_channels() / 2 + 1)
            send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        send_item(pasrb_pkg::CMD_DRAIN, pick_raw(), pick_raw());
        settle_block();
    endtask

    task automatic test_channel_count_and_pins();
        int guard;
        write_register(pasrb_pkg::REG_PIN_MAP, '1);
        send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        settle_block();
        write_register(pasrb_pkg::REG_PIN_MAP, 64'h0123_4567_89AB_CDEF);

        // Park on the top pair, then shrink the count under it
        guard = 0;
        while (cur_pair != 3 && guard < 8)
        begin
            send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
            guard++;
        end
        settle_block();
        write_register(pasrb_pkg::REG_CHANNEL_COUNT, pasrb_pkg::CFG_DATA_W'(2));
        send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        settle_block();

        apply_channel_count(4'd0);
        apply_channel_count(4'd1);
        apply_channel_count(4'd5);
        apply_channel_count(4'd15);
        apply_channel_count(4'd7);
    endtask

    // Stall results for a long stretch while commands keep coming
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        repeat (30)
        begin
            if ($urandom_range(1))
                send_item(pasrb_pkg::CMD_DRAIN, pick_raw(), pick_raw());
            else
                send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
        end
        settle_block();
    endtask

    // Mostly whole scan frames and drain runs, with stray commands mixed in
    task automatic test_random_traffic(int item_goal);
        int sent;
        int choice;
        int burst;
        sent = 0;
        while (sent < item_goal)
        begin
            choice = $urandom_range(99);
            if (choice < 50)
            begin
                burst = active_channels() / 2 - cur_pair;
                if (burst < 1)
                    burst = 1;
                repeat (burst) send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
                sent += burst;
            end
            else if (choice < 80)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst) send_item(pasrb_pkg::CMD_DRAIN, pick_raw(), pick_raw());
                sent += burst;
            end
            else if (choice < 88)
            begin
                send_item(pasrb_pkg::CMD_CLEAR, pick_raw(), pick_raw());
                sent++;
            end
            else if (choice < 93)
            begin
                send_item(CMD_UNUSED, pick_raw(), pick_raw());
            end
            else
            begin
                send_item(pasrb_pkg::CMD_SAMPLE, pick_raw(), pick_raw());
                sent++;
            end
        end
        settle_block();
    endtask

    initial
    begin
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= pasrb_pkg::CMD_SAMPLE;
        cmd_ch.first_sample <= '0;
        cmd_ch.second_sample <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_status_and_refusal();
        test_fill_until_halt();
        test_channel_count_and_pins();
        test_result_backpressure();

        write_register(pasrb_pkg::REG_CHANNEL_COUNT, pasrb_pkg::CFG_DATA_W'(8));
        write_register(pasrb_pkg::REG_PIN_MAP, {$urandom, $urandom});
        test_random_traffic(160);

        sender_idle_pct = 49;
        receiver_idle_pct = 14;
        write_register(pasrb_pkg::REG_CHANNEL_COUNT, pasrb_pkg::CFG_DATA_W'(2));
        write_register(pasrb_pkg::REG_PIN_MAP, '0);
        test_random_traffic(150);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_register(pasrb_pkg::REG_CHANNEL_COUNT, pasrb_pkg::CFG_DATA_W'(6));
        write_register(pasrb_pkg::REG_PIN_MAP, {$urandom, $urandom});
        test_random_traffic(150);

        // Let any late result show up before the verdict
        repeat (20) @(posedge clk);
        if (failures == 0 && results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
